>>> sv/sha_pkg.sv
`timescale 1ns / 1ps
package sha_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned BlkWords = 16;
  localparam int unsigned BlkAw    = 4;
  localparam int unsigned Rounds   = 64;
  localparam int unsigned RndW     = 6;

  localparam logic [WordW-1:0] PadWord = 32'h8000_0000;
  localparam logic [7:0]       PadByte = 8'h80;

  function automatic logic [WordW-1:0] iv_val(input logic [2:0] i);
    logic [WordW-1:0] r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      3'd7: r = 32'h5be0cd19;
      default: r = '0;
    endcase
    return r;
  endfunction

  localparam logic [WordW-1:0] RcTab [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

endpackage

>>> sv/sha_ram.sv
`timescale 1ns / 1ps
module sha_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> sv/sha256_message_digest.sv
`timescale 1ns / 1ps
// SHA-256 hash engine.
// Input channel: one 32-bit big-endian message word per handshake
// (msg_word_i, valid_bytes_i, final_word_i with in_valid_i / in_stall_o).
// valid_bytes_i matters on the final word only (0..4, above 4 counts as 4).
// Output channel: the 256-bit digest as digest_w0_o..digest_w7_o with
// out_valid_o / out_stall_i, one digest per message, after the final word.
// Each word is written into a 16-entry block RAM. A word that fills a block
// stalls the input while the RAM read is primed, the 64 rounds run and the
// chaining step adds into the hash. Block words are read from the RAM in the
// cycle before their round; the schedule window sits in registers.
// The final word drives padding: pad words are written one per cycle and one
// or two compressions run; the digest shows on out_valid_o after the last
// compression when the output register is free.
// The digest waits in an output register, so the next message is taken while
// out_stall_i holds it; a second digest holds its chaining step, and with it
// the input, until the first one is taken.
// Reset (rst_ni low, asynchronous) loads the initial hash values and clears
// the fill count and length; RAM contents need no clearing.
module sha256_message_digest
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] msg_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        final_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_w0_o,
  output logic [31:0] digest_w1_o,
  output logic [31:0] digest_w2_o,
  output logic [31:0] digest_w3_o,
  output logic [31:0] digest_w4_o,
  output logic [31:0] digest_w5_o,
  output logic [31:0] digest_w6_o,
  output logic [31:0] digest_w7_o
);

  typedef enum logic [2:0] {
    StIdle, StPrime, StRound, StChain, StPad
  } state_e;

  state_e           state_q;
  logic [BlkAw-1:0] fill_q;
  logic [63:0]      len_q;
  logic [WordW-1:0] h_q [8];
  logic [WordW-1:0] v_q [8];
  logic [RndW-1:0]  rnd_q;
  logic             fin_q;     // compression belongs to final padding
  logic             pad1_q;    // 0x80 word still owed (full final word)
  logic             lhi_q;     // length high word written in this block
  logic             out_valid_q;
  logic [WordW-1:0] dig_q [8];

  // schedule window: w[t-16..t-1] mirrored in regs for taps, RAM holds block
  logic [WordW-1:0] win_q [16];

  logic             we;
  logic [BlkAw-1:0] waddr, raddr;
  logic [WordW-1:0] wdata, rdata;

  sha_ram #(.Width(WordW), .Depth(BlkWords)) u_blk (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic        acc;
  logic        out_take;
  logic        dig_free;
  logic        fin_chain;
  logic [2:0]  nb;
  logic [WordW-1:0] keep, last_w;

  assign in_stall_o  = (state_q != StIdle);
  assign acc         = in_valid_i && (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_take    = out_valid_q && !out_stall_i;
  assign dig_free    = !out_valid_q || !out_stall_i;
  assign fin_chain   = (state_q == StChain) && fin_q && lhi_q && dig_free;
  assign digest_w0_o = dig_q[0];
  assign digest_w1_o = dig_q[1];
  assign digest_w2_o = dig_q[2];
  assign digest_w3_o = dig_q[3];
  assign digest_w4_o = dig_q[4];
  assign digest_w5_o = dig_q[5];
  assign digest_w6_o = dig_q[6];
  assign digest_w7_o = dig_q[7];

  always_comb begin
    nb = (valid_bytes_i > 3'd4) ? 3'd4 : valid_bytes_i;
    case (nb)
      3'd0: keep = 32'h0000_0000;
      3'd1: keep = 32'hff00_0000;
      3'd2: keep = 32'hffff_0000;
      3'd3: keep = 32'hffff_ff00;
      default: keep = 32'hffff_ffff;
    endcase
    case (nb)
      3'd0: last_w = {PadByte, 24'h0};
      3'd1: last_w = (msg_word_i & keep) | {8'h0, PadByte, 16'h0};
      3'd2: last_w = (msg_word_i & keep) | {16'h0, PadByte, 8'h0};
      3'd3: last_w = (msg_word_i & keep) | {24'h0, PadByte};
      default: last_w = msg_word_i;
    endcase
  end

  // pad word for the current fill slot; length low word only after length high
  logic [WordW-1:0] pad_w;
  always_comb begin
    if (pad1_q) pad_w = PadWord;
    else if (fill_q == 4'd14) pad_w = len_q[63:32];
    else if (fill_q == 4'd15 && lhi_q) pad_w = len_q[31:0];
    else pad_w = '0;
  end

  // round datapath
  logic [WordW-1:0] wt, sig1, ch, t1, sig0, maj, t2, s0, s1, wnew;
  always_comb begin
    s0   = rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3);
    s1   = rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10);
    wnew = win_q[0] + s0 + win_q[9] + s1;
    wt   = (rnd_q < 6'd16) ? rdata : wnew;
    sig1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1   = v_q[7] + sig1 + ch + RcTab[rnd_q] + wt;
    sig0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2   = sig0 + maj;
  end

  always_comb begin
    we = 1'b0; waddr = fill_q; wdata = '0;
    raddr = '0;
    if (acc) begin
      we = 1'b1;
      wdata = (final_word_i && nb != 3'd4) ? last_w : msg_word_i;
    end else if (state_q == StPad) begin
      we = 1'b1;
      wdata = pad_w;
    end
    if (state_q == StRound) raddr = rnd_q[BlkAw-1:0] + 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      len_q       <= '0;
      rnd_q       <= '0;
      fin_q       <= 1'b0;
      pad1_q      <= 1'b0;
      lhi_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h_q[i]   <= iv_val(3'(i));
        v_q[i]   <= '0;
        dig_q[i] <= '0;
      end
      for (int i = 0; i < 16; i++) win_q[i] <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (acc) begin
            fill_q <= fill_q + 4'd1;
            if (!final_word_i) begin
              len_q <= len_q + 64'd32;
              if (fill_q == 4'd15) state_q <= StPrime;
            end else begin
              len_q   <= len_q + {58'd0, nb, 3'd0};
              fin_q   <= 1'b1;
              pad1_q  <= (nb == 3'd4);
              state_q <= (fill_q == 4'd15) ? StPrime : StPad;
            end
          end
        end
        StPad: begin
          pad1_q <= 1'b0;
          if (!pad1_q && fill_q == 4'd14) lhi_q <= 1'b1;
          fill_q <= fill_q + 4'd1;
          if (fill_q == 4'd15) state_q <= StPrime;
        end
        StPrime: begin
          rnd_q <= '0;
          for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
          state_q <= StRound;
        end
        StRound: begin
          for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
          win_q[15] <= wt;
          v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
          v_q[0] <= t1 + t2;
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'(Rounds - 1)) state_q <= StChain;
        end
        StChain: begin
          if (!fin_q) begin
            for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
            state_q <= StIdle;
          end else if (!lhi_q) begin
            for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
            state_q <= StPad;
          end else if (dig_free) begin
            // last block done: hand off the digest and restart the chain
            for (int i = 0; i < 8; i++) begin
              dig_q[i] <= h_q[i] + v_q[i];
              h_q[i]   <= iv_val(3'(i));
            end
            len_q   <= '0;
            fin_q   <= 1'b0;
            lhi_q   <= 1'b0;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase

      if (fin_chain) out_valid_q <= 1'b1;
      else if (out_take) out_valid_q <= 1'b0;
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        last;
  } msg_word_t;

  typedef logic [255:0] digest_t;

  localparam int unsigned WatchdogLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] msg_word_i = '0;
  logic [2:0]  valid_bytes_i = '0;
  logic        final_word_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] digest_w0_o, digest_w1_o, digest_w2_o, digest_w3_o;
  logic [31:0] digest_w4_o, digest_w5_o, digest_w6_o, digest_w7_o;

  sha256_message_digest dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .msg_word_i, .valid_bytes_i,
    .final_word_i, .out_valid_o, .out_stall_i, .digest_w0_o, .digest_w1_o,
    .digest_w2_o, .digest_w3_o, .digest_w4_o, .digest_w5_o, .digest_w6_o,
    .digest_w7_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hash model state
  logic [31:0] hash_h [8];
  logic [31:0] blk_buf [16];
  int unsigned blk_fill;
  logic [63:0] msg_bits;

  msg_word_t pending_words[$];
  digest_t   digest_queue[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  bit          in_taken = 1'b0;
  int unsigned errors = 0;
  int unsigned watchdog = 0;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_blk();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int t = 0; t < 16; t++) w[t] = blk_buf[t];
    for (int t = 16; t < 64; t++)
      w[t] = w[t-16] + w[t-7]
           + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3))
           + (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10));
    {a, b, c, d, e, f, g, h} = {hash_h[0], hash_h[1], hash_h[2], hash_h[3],
                                hash_h[4], hash_h[5], hash_h[6], hash_h[7]};
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + RoundK[t] + w[t];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d;
    hash_h[4] += e; hash_h[5] += f; hash_h[6] += g; hash_h[7] += h;
  endtask

  task automatic append_word(logic [31:0] w);
    blk_buf[blk_fill] = w;
    blk_fill = (blk_fill + 1) % 16;
    if (blk_fill == 0) compress_blk();
  endtask

  task automatic hash_accept(msg_word_t m);
    int unsigned nb;
    logic [31:0] keep;
    if (!m.last) begin
      append_word(m.data);
      msg_bits += 32;
      return;
    end
    nb = (m.nbytes > 4) ? 4 : m.nbytes;
    msg_bits += nb * 8;
    if (nb == 4) begin
      append_word(m.data);
      append_word(32'h8000_0000);
    end else begin
      keep = (nb == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * nb));
      append_word((m.data & keep) | (32'h80 << (24 - 8 * nb)));
    end
    while (blk_fill != 14) append_word(32'h0);
    append_word(msg_bits[63:32]);
    append_word(msg_bits[31:0]);
    digest_queue.push_back({hash_h[0], hash_h[1], hash_h[2], hash_h[3],
                            hash_h[4], hash_h[5], hash_h[6], hash_h[7]});
    hash_h = InitHash;
    blk_fill = 0;
    msg_bits = '0;
  endtask

  // Driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        // hold stalled word
      end else if (pending_words.size() > 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        {msg_word_i, valid_bytes_i, final_word_i} <= pending_words.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall, with a counted long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Monitor, reference update and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken = in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o)
        hash_accept('{msg_word_i, valid_bytes_i, final_word_i});
      if (out_valid_o && !out_stall_i) begin
        if (digest_queue.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected digest %h", digest_w0_o);
        end else begin
          digest_t exp_d, got_d;
          exp_d = digest_queue.pop_front();
          got_d = {digest_w0_o, digest_w1_o, digest_w2_o, digest_w3_o,
                   digest_w4_o, digest_w5_o, digest_w6_o, digest_w7_o};
          for (int i = 0; i < 8; i++)
            if (got_d[255-32*i -: 32] !== exp_d[255-32*i -: 32]) begin
              errors++;
              if (errors <= 10)
                $display("digest_w%0d: expected %h got %h", i,
                         exp_d[255-32*i -: 32], got_d[255-32*i -: 32]);
            end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          hold_left > 0)
        watchdog <= 0;
      else if (in_valid_i || digest_queue.size() > 0)
        watchdog <= watchdog + 1;
      if (watchdog >= WatchdogLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic add_message(int unsigned nwords, int unsigned tail_bytes, bit clean);
    msg_word_t m;
    for (int unsigned i = 0; i < nwords; i++) begin
      m.data = $urandom();
      m.nbytes = clean ? 3'd4 : 3'($urandom_range(7));
      m.last = 1'b0;
      pending_words.push_back(m);
    end
    m.data = $urandom();
    m.nbytes = 3'(tail_bytes);
    m.last = 1'b1;
    pending_words.push_back(m);
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid_i || digest_queue.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic random_phase(int unsigned nmsg);
    for (int unsigned k = 0; k < nmsg; k++) begin
      // short messages mostly, with tails around the two-block padding boundary
      if ($urandom_range(3) == 0)
        add_message($urandom_range(12, 17), $urandom_range(7), $urandom_range(3) != 0);
      else
        add_message($urandom_range(0, 6), $urandom_range(7), $urandom_range(3) != 0);
    end
  endtask

  initial begin
    msg_word_t m;
    hash_h = InitHash;
    blk_fill = 0;
    msg_bits = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: empty message, each tail size, extremes, 55/56/63/64-byte tails
    for (int unsigned nb = 0; nb < 8; nb++) add_message(0, nb, 1'b1);
    m = '{32'hffff_ffff, 3'd7, 1'b0};
    pending_words.push_back(m);
    m = '{32'hffff_ffff, 3'd3, 1'b1};
    pending_words.push_back(m);
    m = '{32'h0, 3'd0, 1'b0};
    pending_words.push_back(m);
    m = '{32'h0, 3'd4, 1'b1};
    pending_words.push_back(m);
    add_message(13, 3, 1'b1);
    add_message(13, 4, 1'b1);
    add_message(14, 0, 1'b0);
    add_message(15, 3, 1'b1);
    add_message(15, 4, 1'b1);
    drain();

    send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(28);  drain();
    send_idle_pct = 49; recv_stall_pct = 0;  random_phase(24);  drain();
    send_idle_pct = 0;  recv_stall_pct = 49; random_phase(24);  drain();
    send_idle_pct = 18; recv_stall_pct = 18; random_phase(24);  drain();

    // long receiver hold-off while words keep coming
    @(negedge clk_i);
    hold_left = 3000;
    send_idle_pct = 0;
    random_phase(8);
    drain();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
